>>> rtl/rsbk_pkg.sv
// Package: shared types, constants and the float key mapping for the row sorter.
`timescale 1ns / 1ps
`default_nettype none
package rsbk_pkg;
	localparam int MAX_ROWS_DEF = 64;
	localparam int COLUMNS      = 4;
	localparam int COL_W        = 32;
	localparam int KEY_W        = 32;
	localparam int PADDR_W      = 3;
	localparam logic [PADDR_W-1:0] ADDR_KEY_COLUMN = 3'd0;

	typedef struct packed {
		logic [COL_W-1:0] in_col_0;
		logic [COL_W-1:0] in_col_1;
		logic [COL_W-1:0] in_col_2;
		logic [COL_W-1:0] in_col_3;
		logic             in_last_row;
	} in_row_t;

	typedef struct packed {
		logic [COL_W-1:0] out_col_0;
		logic [COL_W-1:0] out_col_1;
		logic [COL_W-1:0] out_col_2;
		logic [COL_W-1:0] out_col_3;
		logic             out_last_row;
		logic             overflowed;
	} out_row_t;

	typedef struct packed {
		logic [COL_W-1:0] c0;
		logic [COL_W-1:0] c1;
		logic [COL_W-1:0] c2;
		logic [COL_W-1:0] c3;
	} row_t;

	// compare unit verdict
	typedef struct packed {
		logic qual;
		logic better;
	} cmp_res_t;

	// map an IEEE single to an unsigned value ordering like the float
	function automatic logic [KEY_W-1:0] map_key(input logic [COL_W-1:0] bits);
		logic [KEY_W-1:0] r;
		if (bits[30:0] == 31'd0) begin
			r = 32'h8000_0000;
		end else if (bits[31]) begin
			r = ~bits;
		end else begin
			r = bits | 32'h8000_0000;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/record_sorter_by_key_column.sv
// Top level: row collector and stable selection sorter on a float key column.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_stall   | in_data  (rsbk_pkg::in_row_t)
//  out     | out | out_valid / out_stall | out_data (rsbk_pkg::out_row_t)
//  apb     | in  | psel/penable/pwrite   | paddr, pwdata, prdata (key_column)
//
// Rows are taken one per cycle while collecting. On the last row the block
// stalls its input and runs n selection passes over the n stored rows; each
// pass reads every row through the single memory read port, in state RD then
// state CMP for each row, then hands the chosen row to the result register in
// state EMIT, where output stalls hold the pass.
// Reset clears the count, overflow flag and sequencer; the store is not cleared.
// An output stall holds the result register and holds the sequencer in its emit state.
`timescale 1ns / 1ps
`default_nettype none
module record_sorter_by_key_column #(
	parameter int MAX_ROWS = rsbk_pkg::MAX_ROWS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  rsbk_pkg::in_row_t             in_data,
	output logic                          out_valid,
	input  wire                           out_stall,
	output rsbk_pkg::out_row_t            out_data,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [rsbk_pkg::PADDR_W-1:0]   paddr,
	input  wire [31:0]                    pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ROWS);

	typedef enum logic [3:0] {
		ST_COLLECT = 4'b0001,
		ST_RD      = 4'b0010,
		ST_CMP     = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [1:0]                  key_column_q;
	logic [CW-1:0]               count_q;
	logic                        ovf_q;
	logic [CW-1:0]               scan_q;   // row under test
	logic [CW-1:0]               pos_q;    // results sent so far
	logic                        have_prev_q;
	logic [rsbk_pkg::KEY_W-1:0]  prev_key_q;
	logic [CW-1:0]               prev_idx_q;
	logic                        found_q;
	logic [rsbk_pkg::KEY_W-1:0]  best_key_q;
	logic [CW-1:0]               best_idx_q;
	rsbk_pkg::row_t              best_row_q;
	logic                        out_valid_q;
	rsbk_pkg::out_row_t          out_data_q;

	logic                        in_acc;
	logic                        cfg_wr;
	logic [1:0]                  key_sel;
	rsbk_pkg::row_t              wrow;
	rsbk_pkg::row_t              rrow;
	logic [rsbk_pkg::KEY_W-1:0]  cur_key;
	rsbk_pkg::cmp_res_t          cmp;
	logic                        out_free;

	assign pready   = 1'b1;
	assign prdata   = {30'd0, key_column_q};
	assign cfg_wr   = psel && penable && pwrite && (paddr == rsbk_pkg::ADDR_KEY_COLUMN);
	assign in_stall = (state_q != ST_COLLECT);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// a key column beyond the row saturates to the last column
	assign key_sel = (32'(key_column_q) >= rsbk_pkg::COLUMNS) ?
		2'(rsbk_pkg::COLUMNS - 1) : key_column_q;

	assign wrow = '{c0: in_data.in_col_0, c1: in_data.in_col_1,
		c2: in_data.in_col_2, c3: in_data.in_col_3};

	rsbk_row_mem #(.MAX_ROWS(MAX_ROWS)) u_mem (
		.clk   (clk),
		.we    (in_acc && (count_q < FULL)),
		.waddr (count_q[AW-1:0]),
		.wdata (wrow),
		.raddr (scan_q[AW-1:0]),
		.rdata (rrow)
	);

	rsbk_key_cmp #(.IW(CW)) u_cmp (
		.row       (rrow),
		.key_sel   (key_sel),
		.idx       (scan_q),
		.have_prev (have_prev_q),
		.prev_key  (prev_key_q),
		.prev_idx  (prev_idx_q),
		.found     (found_q),
		.best_key  (best_key_q),
		.key       (cur_key),
		.res       (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_column_q <= 2'd0;
		end else if (cfg_wr) begin
			key_column_q <= pwdata[1:0];
		end
	end

	// payload registers of the selection pass and the result
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && cmp.qual && cmp.better) begin
			best_key_q <= cur_key;
			best_idx_q <= scan_q;
			best_row_q <= rrow;
		end
		if (state_q == ST_EMIT && out_free) begin
			prev_key_q <= best_key_q;
			prev_idx_q <= best_idx_q;
			out_data_q <= '{out_col_0: best_row_q.c0, out_col_1: best_row_q.c1,
				out_col_2: best_row_q.c2, out_col_3: best_row_q.c3,
				out_last_row: (pos_q + 1'b1 == count_q), overflowed: ovf_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			pos_q       <= '0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (count_q < FULL) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_data.in_last_row) begin
							state_q     <= ST_RD;
							scan_q      <= '0;
							pos_q       <= '0;
							have_prev_q <= 1'b0;
							found_q     <= 1'b0;
						end
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (cmp.qual && cmp.better) begin
						found_q <= 1'b1;
					end
					if (scan_q + 1'b1 == count_q) begin
						state_q <= ST_EMIT;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						have_prev_q <= 1'b1;
						found_q     <= 1'b0;
						scan_q      <= '0;
						if (pos_q + 1'b1 == count_q) begin
							state_q <= ST_COLLECT;
							count_q <= '0;
							ovf_q   <= 1'b0;
							pos_q   <= '0;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("row count beyond capacity");

	// a last row starts the sort at once
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.in_last_row |=> state_q == ST_RD) else $error("sort not started");

	// while sorting, the scan and result positions stay inside the stored set
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_COLLECT |-> (pos_q < count_q) && (scan_q < count_q))
		else $error("sort index outside stored rows");

	// every pass finds a row to emit
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> found_q) else $error("emit with no selected row");
endmodule
`default_nettype wire

>>> rtl/rsbk_row_mem.sv
// Row store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rsbk_row_mem #(
	parameter int MAX_ROWS = rsbk_pkg::MAX_ROWS_DEF
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire [$clog2(MAX_ROWS)-1:0]   waddr,
	input  rsbk_pkg::row_t               wdata,
	input  wire [$clog2(MAX_ROWS)-1:0]   raddr,
	output rsbk_pkg::row_t               rdata
);
	rsbk_pkg::row_t mem_q [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/rsbk_key_cmp.sv
// Shared compare unit: maps the key, ranks (key, index) against previous and the key against best.
`timescale 1ns / 1ps
`default_nettype none
module rsbk_key_cmp #(
	parameter int IW = 7
) (
	input  rsbk_pkg::row_t                row,
	input  wire [1:0]                     key_sel,
	input  wire [IW-1:0]                  idx,
	input  wire                           have_prev,
	input  wire [rsbk_pkg::KEY_W-1:0]     prev_key,
	input  wire [IW-1:0]                  prev_idx,
	input  wire                           found,
	input  wire [rsbk_pkg::KEY_W-1:0]     best_key,
	output logic [rsbk_pkg::KEY_W-1:0]    key,
	output rsbk_pkg::cmp_res_t            res
);
	logic [rsbk_pkg::COL_W-1:0] col;

	always_comb begin
		case (key_sel)
			2'd0:    col = row.c0;
			2'd1:    col = row.c1;
			2'd2:    col = row.c2;
			default: col = row.c3;
		endcase
		key = rsbk_pkg::map_key(col);
		res.qual = !have_prev || (key > prev_key) || ((key == prev_key) && (idx > prev_idx));
		// strict: a later row with an equal key never displaces the earlier one
		res.better = !found || (key < best_key);
	end
endmodule
`default_nettype wire

>>> tb/tb_record_sorter_by_key_column.sv
// Testbench: random and directed row sets checked against a behavioural sorted-row predictor.
`timescale 1ns / 1ps
module tb_record_sorter_by_key_column;

	localparam int NROWS = rsbk_pkg::MAX_ROWS_DEF;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rsbk_pkg::in_row_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsbk_pkg::out_row_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rsbk_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	record_sorter_by_key_column dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state: collected rows, count, overflow flag, key column
	rsbk_pkg::row_t held_rows[NROWS];
	int unsigned held_count;
	bit held_ovf;
	logic [1:0] sort_col;

	rsbk_pkg::in_row_t pending_rows[$];
	rsbk_pkg::out_row_t sorted_expect[$];
	int mismatches;
	int idle_cycles;
	bit hold_send;

	function automatic logic [31:0] float_order(input logic [31:0] b);
		if (b[30:0] == 31'd0) return 32'h8000_0000;
		if (b[31]) return ~b;
		return b | 32'h8000_0000;
	endfunction

	function automatic logic [31:0] key_of(input rsbk_pkg::row_t r, input logic [1:0] c);
		case (c)
			2'd0: return r.c0;
			2'd1: return r.c1;
			2'd2: return r.c2;
			default: return r.c3;
		endcase
	endfunction

	// takes one accepted row; on the last row queues the set in stable key order
	task automatic predict_row(input rsbk_pkg::in_row_t it);
		int idx[NROWS];
		int i, j, t;
		rsbk_pkg::out_row_t o;
		if (held_count < NROWS) begin
			held_rows[held_count] = '{it.in_col_0, it.in_col_1, it.in_col_2, it.in_col_3};
			held_count++;
		end else begin
			held_ovf = 1'b1;
		end
		if (!it.in_last_row) return;
		for (i = 0; i < held_count; i++) begin
			j = i;
			while (j > 0 && float_order(key_of(held_rows[idx[j-1]], sort_col)) >
					float_order(key_of(held_rows[i], sort_col))) begin
				idx[j] = idx[j-1];
				j--;
			end
			idx[j] = i;
		end
		for (i = 0; i < held_count; i++) begin
			t = idx[i];
			o.out_col_0 = held_rows[t].c0;
			o.out_col_1 = held_rows[t].c1;
			o.out_col_2 = held_rows[t].c2;
			o.out_col_3 = held_rows[t].c3;
			o.out_last_row = (i + 1 == held_count);
			o.overflowed = held_ovf;
			sorted_expect.push_back(o);
		end
		held_count = 0;
		held_ovf = 1'b0;
	endtask

	// sender: random idle gap before each item
	int send_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_row(in_data);
				void'(pending_rows.pop_front());
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 9);
			end else if (!in_valid) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_rows.size() > 0 && !hold_send) begin
					in_data <= pending_rows[0];
					in_valid <= 1'b1;
				end
			end
		end
	end

	// receiver: random stall after each item; compare with oldest expectation
	int stall_left;
	rsbk_pkg::out_row_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (sorted_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sorted row %h", out_data);
				end else begin
					want = sorted_expect.pop_front();
					if (want !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("row mismatch: expected %h got %h", want, out_data);
					end
				end
				stall_left = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) stall_left = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles with no acceptance on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_key(input logic [1:0] c);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= rsbk_pkg::ADDR_KEY_COLUMN;
		pwdata <= ({$urandom} & ~32'h3) | {30'd0, c};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sort_col = c;
	endtask

	// waits until the block has drained every expected row, then a latency margin
	task automatic drain;
		while (pending_rows.size() > 0 || in_valid || sorted_expect.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic push_row(input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3, input logic last);
		rsbk_pkg::in_row_t r;
		r.in_col_0 = c0;
		r.in_col_1 = c1;
		r.in_col_2 = c2;
		r.in_col_3 = c3;
		r.in_last_row = last;
		pending_rows.push_back(r);
	endtask

	function automatic logic [31:0] rand_float;
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000;
			3: return 32'hFF80_0000;
			4: return 32'h7FC0_0000 | $urandom_range(0, 255);
			5: return 32'hFFC0_0000 | $urandom_range(0, 255);
			6: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 3))};
			7: return {1'($urandom_range(0, 1)), 8'h3F, 23'($urandom_range(0, 7))};
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_set(input int n, input bit randoms);
		rsbk_pkg::in_row_t r;
		int i;
		for (i = 0; i < n; i++) begin
			r.in_col_0 = randoms ? rand_float() : $urandom;
			r.in_col_1 = rand_float();
			r.in_col_2 = rand_float();
			r.in_col_3 = rand_float();
			r.in_last_row = (i == n - 1);
			pending_rows.push_back(r);
		end
	endtask

	initial begin
		int i, sent;
		mismatches = 0; idle_cycles = 0; send_gap = 0; stall_left = 0;
		held_count = 0; held_ovf = 0; sort_col = 2'd0; hold_send = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: single-row set at reset key, then signed zeros, infinities, NaNs
		push_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1);
		push_row(32'h8000_0000, 32'h1, 32'h2, 32'h3, 1'b0);
		push_row(32'h0000_0000, 32'h4, 32'h5, 32'h6, 1'b0);
		push_row(32'h7FC0_0000, 32'h7, 32'h8, 32'h9, 1'b0);
		push_row(32'hFFC0_0001, 32'hA, 32'hB, 32'hC, 1'b0);
		push_row(32'h7F80_0000, 32'hD, 32'hE, 32'hF, 1'b0);
		push_row(32'hFF80_0000, 32'h10, 32'h11, 32'h12, 1'b0);
		push_row(32'h3F80_0000, 32'h13, 32'h14, 32'h15, 1'b1);
		drain();
		// key changed mid-set: the sort uses the key standing at the last row
		write_key(2'd3);
		queue_set(3, 1);
		void'(pending_rows.pop_back());
		drain();
		write_key(2'd1);
		push_row(32'h0, 32'hBF80_0000, 32'h0, 32'h0, 1'b1);
		drain();

		// random sets, mostly small, key column varied
		sent = 11;
		while (sent < 91) begin
			write_key(2'($urandom_range(0, 3)));
			i = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			queue_set(i, 1);
			sent += i;
			drain();
		end
		// full store plus dropped rows, last row dropped too
		write_key(2'd2);
		queue_set(NROWS + 3, 1);
		drain();
		write_key(2'd0);
		queue_set(8, 1);
		// hold the sender for a while before the set goes out
		hold_send = 1;
		repeat (50) @(posedge clk);
		hold_send = 0;
		drain();
		write_key(2'd3);
		queue_set(4, 1);
		drain();

		if (mismatches == 0 && sorted_expect.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

>>> filelist.f
rtl/rsbk_pkg.sv
rtl/rsbk_row_mem.sv
rtl/rsbk_key_cmp.sv
rtl/record_sorter_by_key_column.sv
tb/tb_record_sorter_by_key_column.sv
